>>> hw/rtl/b64d_pkg.sv
// shared types, constants and the alphabet lookup for the base64 stream decoder
`default_nettype none

package b64d_pkg;

   // alphabet anchors
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharDigit0 = 8'h30;
   localparam logic [7:0] CharDigit9 = 8'h39;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharSlash  = 8'h2F;

   // sextet values where each alphabet range starts
   localparam logic [5:0] SextetLowerBase = 6'd26;
   localparam logic [5:0] SextetDigitBase = 6'd52;
   localparam logic [5:0] SextetPlus      = 6'd62;
   localparam logic [5:0] SextetSlash     = 6'd63;

   // results one character can raise, and the reset maximum
   localparam int unsigned ResultDepth  = 3;
   localparam logic [15:0] MaxBytesReset = 16'd64;

   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sextet_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_status;
      logic [15:0] bytes_total;
      logic        complete;
   } result_type;

   // map one character to its sextet; ok low marks a terminator
   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      s.ok  = 1'b1;
      s.val = 6'd0;
      case (ch) inside
         [CharUpperA:CharUpperZ]: begin
            s.val = 6'(ch - CharUpperA);
         end
         [CharLowerA:CharLowerZ]: begin
            s.val = 6'(ch - CharLowerA) + SextetLowerBase;
         end
         [CharDigit0:CharDigit9]: begin
            s.val = 6'(ch - CharDigit0) + SextetDigitBase;
         end
         CharPlus: begin
            s.val = SextetPlus;
         end
         CharSlash: begin
            s.val = SextetSlash;
         end
         default: begin
            s.ok = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/base64_stream_decoder_top.sv
// base64 stream decoder: character in, decoded bytes and end-of-string status out
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_char_code, req_start_string
//  rsp     | out       | rsp_valid / rsp_ready | rsp_out_byte, rsp_is_status,
//          |           |                       | rsp_bytes_total, rsp_complete,
//          |           |                       | rsp_last_of_run
//  csr     | in        | csr_valid / csr_ready | csr_max_bytes
//
// A character is decoded in the cycle it is accepted; its results (none to three)
// land in a three-entry result buffer that the rsp side drains one beat a cycle while rsp_ready is high.
// A character giving at most one result flows at one per cycle while rsp_ready is high; one
// that gives more results holds req_ready low until the buffer drains to its last beat.
// Synchronous reset clears the decoder state, empties the buffer and sets max_bytes to 64.
// A stall on rsp holds the current beat; req_ready drops until the buffer frees.
`default_nettype none

module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_start_string,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_is_status,
   output      logic [15:0] rsp_bytes_total,
   output      logic        rsp_complete,
   output      logic        rsp_last_of_run,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_max_bytes
);

   logic [15:0] max_bytes_ff;
   logic [17:0] store_ff,  store_in;
   logic [1:0]  fill_ff,   fill_in;
   logic [15:0] count_ff,  count_in;
   logic        stopped_ff, stopped_in;
   result_type  buf_ff [ResultDepth];
   result_type  buf_in [ResultDepth];
   logic [1:0]  num_ff, num_in;
   logic [1:0]  rd_ff;

   logic        req_fire;
   logic        rsp_fire;
   logic        last_beat;

   // working copies of the state after an optional string start
   logic [17:0] cur_store;
   logic [1:0]  cur_fill;
   logic [15:0] cur_count;
   logic        cur_stopped;
   sextet_type  sx;
   logic [23:0] group;
   logic [7:0]  want_byte [ResultDepth];
   logic [1:0]  want_num;
   logic [15:0] run_count;

   assign csr_ready = 1'b1;

   // handshakes and drain position
   assign rsp_valid = (rd_ff != num_ff);
   assign last_beat = ((rd_ff + 2'd1) == num_ff);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (rsp_ready && last_beat);
   assign req_fire  = req_valid && req_ready;

   // output beat from the buffer
   assign rsp_out_byte    = buf_ff[rd_ff].out_byte;
   assign rsp_is_status   = buf_ff[rd_ff].is_status;
   assign rsp_bytes_total = buf_ff[rd_ff].bytes_total;
   assign rsp_complete    = buf_ff[rd_ff].complete;
   assign rsp_last_of_run = last_beat;

   // decode one character into results and next state
   always_comb begin
      cur_store   = req_start_string ? 18'd0 : store_ff;
      cur_fill    = req_start_string ? 2'd0  : fill_ff;
      cur_count   = req_start_string ? 16'd0 : count_ff;
      cur_stopped = req_start_string ? 1'b0  : stopped_ff;
      sx          = sextet_of(req_char_code);
      group       = {cur_store, sx.val};

      store_in   = cur_store;
      fill_in    = cur_fill;
      count_in   = cur_count;
      stopped_in = cur_stopped;
      num_in     = 2'd0;
      run_count  = cur_count;
      for (int i = 0; i < ResultDepth; i++) begin
         buf_in[i]    = buf_ff[i];
         want_byte[i] = 8'd0;
      end
      want_num = 2'd0;

      // bytes this character would release
      if (sx.ok) begin
         if (cur_fill == 2'd3) begin
            want_num     = 2'd3;
            want_byte[0] = group[23:16];
            want_byte[1] = group[15:8];
            want_byte[2] = group[7:0];
         end
      end else begin
         if (cur_fill == 2'd2) begin
            want_num     = 2'd1;
            want_byte[0] = cur_store[11:4];
         end else if (cur_fill == 2'd3) begin
            want_num     = 2'd2;
            want_byte[0] = cur_store[17:10];
            want_byte[1] = cur_store[9:2];
         end
      end

      if (!cur_stopped) begin
         // bytes up to the maximum, as a prefix of the buffer
         for (int i = 0; i < ResultDepth; i++) begin
            if ((2'(i) < want_num) && (run_count < max_bytes_ff)) begin
               run_count             = run_count + 16'd1;
               buf_in[i].out_byte    = want_byte[i];
               buf_in[i].is_status   = 1'b0;
               buf_in[i].bytes_total = run_count;
               buf_in[i].complete    = (run_count == max_bytes_ff);
               num_in                = 2'(i + 1);
            end
         end
         count_in = run_count;

         // group update, or end of string with status
         if (sx.ok) begin
            if (cur_fill == 2'd3) begin
               store_in = 18'd0;
               fill_in  = 2'd0;
            end else begin
               store_in = {cur_store[11:0], sx.val};
               fill_in  = cur_fill + 2'd1;
            end
         end else begin
            store_in                   = 18'd0;
            fill_in                    = 2'd0;
            stopped_in                 = 1'b1;
            buf_in[num_in].out_byte    = 8'd0;
            buf_in[num_in].is_status   = 1'b1;
            buf_in[num_in].bytes_total = run_count;
            buf_in[num_in].complete    = (run_count == max_bytes_ff);
            num_in                     = num_in + 2'd1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MaxBytesReset;
         store_ff     <= 18'd0;
         fill_ff      <= 2'd0;
         count_ff     <= 16'd0;
         stopped_ff   <= 1'b0;
         num_ff       <= 2'd0;
         rd_ff        <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_bytes_ff <= csr_max_bytes;
         end
         if (req_fire) begin
            store_ff   <= store_in;
            fill_ff    <= fill_in;
            count_ff   <= count_in;
            stopped_ff <= stopped_in;
            num_ff     <= num_in;
            rd_ff      <= 2'd0;
         end else if (rsp_fire) begin
            rd_ff <= rd_ff + 2'd1;
         end
      end
   end

   // result buffer payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < ResultDepth; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_checker.sv
// port-level checks for the base64 stream decoder, bound to the top level
`default_nettype none

module b64d_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_is_status,
   input wire logic [15:0] rsp_bytes_total,
   input wire logic        rsp_complete,
   input wire logic        rsp_last_of_run
);

   // a stalled beat keeps its byte, its total and its status flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_bytes_total) && $stable(rsp_is_status))
      else $error("rsp beat changed while stalled");

   // nothing is shown straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the status beat closes its run and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_status |-> rsp_last_of_run && (rsp_out_byte == 8'd0))
      else $error("status beat malformed");

   // a data beat always counts at least one byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_status |-> (rsp_bytes_total != 16'd0))
      else $error("data beat with zero total");

   // a data beat after a data beat of the same run counts one more
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_status && !rsp_last_of_run && !rsp_complete
         |=> rsp_valid && (rsp_bytes_total == $past(rsp_bytes_total)
            + {15'd0, !rsp_is_status}))
      else $error("byte total did not advance within a run");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);

`default_nettype wire
